@@ rtl/point_sort_by_origin_distance_defines.svh @@
// ----------------------------------------------------------------------------
// Point sorter assertion macros
// Shared assertion wrappers for the point sorter checker.
// ----------------------------------------------------------------------------
`ifndef POINT_SORT_BY_ORIGIN_DISTANCE_DEFINES_SVH
`define POINT_SORT_BY_ORIGIN_DISTANCE_DEFINES_SVH

// Clocked assertion, masked while reset is asserted
`define PDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define PDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// Point sorter package
// Widths, defaults and shared types for the point sorter.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W        = 16;
  localparam int KEY_W          = 32;
  localparam int IDX_W          = 4;

  // One stored point
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  // Point leaving the key pipeline
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } point_t;

  // Per-cell control
  typedef struct packed {
    logic ins_en;    // insert the broadcast point this cycle
    logic drn_en;    // shift towards the head this cycle
    logic self_vld;  // cell holds a point
    logic left_vld;  // left neighbour holds a point
    logic left_gt;   // left neighbour key is above the new key
  } cell_ctl_t;

endpackage

@@ rtl/pds_key.sv @@
// ----------------------------------------------------------------------------
// Point sorter key pipeline
// Two-stage squared-distance pipeline: squares, then their sum.
// ----------------------------------------------------------------------------
module pds_key (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [pds_pkg::COORD_W-1:0] in_x,
  input  logic signed [pds_pkg::COORD_W-1:0] in_y,
  input  logic                               in_last,
  output logic                               pt_vld,
  output pds_pkg::point_t                    pt
);

  logic signed [2*pds_pkg::COORD_W-1:0] xsq_nxt;
  logic signed [2*pds_pkg::COORD_W-1:0] ysq_nxt;
  logic [pds_pkg::KEY_W-1:0]            xx_r;
  logic [pds_pkg::KEY_W-1:0]            yy_r;
  logic signed [pds_pkg::COORD_W-1:0]   x_r;
  logic signed [pds_pkg::COORD_W-1:0]   y_r;
  logic                                 last_r;
  logic                                 a_vld_r;
  logic                                 b_vld_r;
  pds_pkg::point_t                      pt_r;
  pds_pkg::point_t                      pt_nxt;

  // Squares; a square of a 16-bit value fits 31 bits unsigned
  assign xsq_nxt = in_x * in_x;
  assign ysq_nxt = in_y * in_y;

  // Sum of squares, at most 2^31
  always_comb begin
    pt_nxt.key  = xx_r + yy_r;
    pt_nxt.x    = x_r;
    pt_nxt.y    = y_r;
    pt_nxt.last = last_r;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    xx_r   <= pds_pkg::KEY_W'($unsigned(xsq_nxt));
    yy_r   <= pds_pkg::KEY_W'($unsigned(ysq_nxt));
    x_r    <= in_x;
    y_r    <= in_y;
    last_r <= in_last;
    pt_r   <= pt_nxt;
  end

  assign pt_vld = b_vld_r;
  assign pt     = pt_r;

endmodule

@@ rtl/pds_cell.sv @@
// ----------------------------------------------------------------------------
// Point sorter cell
// One slot of the sorted chain: keeps, takes the new point, takes the left
// neighbour's point on insertion, or the right one's while draining.
// ----------------------------------------------------------------------------
module pds_cell (
  input  logic               clk,
  input  pds_pkg::cell_ctl_t ctl,
  input  pds_pkg::entry_t    new_ent,
  input  pds_pkg::entry_t    left_ent,
  input  pds_pkg::entry_t    right_ent,
  output pds_pkg::entry_t    ent,
  output logic               gt
);

  pds_pkg::entry_t ent_r;
  pds_pkg::entry_t ent_nxt;
  logic            keep;

  // Strictly greater moves aside; equal keys stay ahead of the newcomer
  assign gt   = ctl.self_vld && (ent_r.key > new_ent.key);
  assign keep = ctl.self_vld && !gt;

  // Next slot contents
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.drn_en) begin
      ent_nxt = right_ent;
    end else if (ctl.ins_en && !keep) begin
      if (ctl.left_gt) begin
        ent_nxt = left_ent;
      end else if (ctl.left_vld) begin
        ent_nxt = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

@@ rtl/point_sort_by_origin_distance.sv @@
// ----------------------------------------------------------------------------
// Point sorter by distance from the origin
// Keeps a set of points in ascending order of x*x+y*y and emits them on the
// request marked last, nearest first, earlier arrival first on equal keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (x, y, last) arrive on a valid/ready channel. Each point
//   passes a two-stage squaring pipeline and is then inserted into a chain of
//   MAX_POINTS cells, so points are taken one per cycle while in_ready is high.
//   Points beyond MAX_POINTS are dropped and flag dropped_points on the set.
//   After the request marked last is accepted, in_ready stays low; the chain
//   then drains one point per cycle, while out_ready allows, through a single
//   output register. A stall on out_ready holds the output register and
//   freezes the chain. in_ready rises again once the final point is in the
//   output register, so a new set may load while that result waits.
//   Reset (rst_n low, synchronous) empties the set and clears out_valid.
// ----------------------------------------------------------------------------
module point_sort_by_origin_distance #(
  parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pds_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [pds_pkg::COORD_W-1:0] in_y_coord,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pds_pkg::IDX_W-1:0]          out_point_index,
  output logic signed [pds_pkg::COORD_W-1:0] out_x,
  output logic signed [pds_pkg::COORD_W-1:0] out_y,
  output logic [pds_pkg::KEY_W-1:0]          out_distance_squared,
  output logic                               out_last_out,
  output logic                               out_dropped_points
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic               busy_r;
  logic               drain_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   count_r;
  logic               in_acc;
  logic               pt_vld;
  pds_pkg::point_t    pt;
  logic               full;
  logic               ins_en;
  logic               shift;
  logic               final_shift;
  pds_pkg::entry_t    new_ent;
  pds_pkg::entry_t    ent   [MAX_POINTS];
  logic               gt    [MAX_POINTS];
  logic               vld   [MAX_POINTS];

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  // Squared distance
  pds_key u_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_acc),
    .in_x    (in_x_coord),
    .in_y    (in_y_coord),
    .in_last (in_last_point),
    .pt_vld  (pt_vld),
    .pt      (pt)
  );

  assign full        = (count_r == CNT_W'(MAX_POINTS));
  assign ins_en      = pt_vld && !full;
  assign shift       = drain_r && (!out_valid_r || out_ready);
  assign final_shift = shift && (count_r == CNT_W'(1));

  // Point to insert; arrival number is the current fill, modulo 16
  always_comb begin
    new_ent.key = pt.key;
    new_ent.idx = pds_pkg::IDX_W'(count_r);
    new_ent.x   = pt.x;
    new_ent.y   = pt.y;
  end

  // Sorted chain
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    pds_pkg::cell_ctl_t ctl;
    pds_pkg::entry_t    left_ent;
    pds_pkg::entry_t    right_ent;

    assign vld[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign ctl.left_vld = 1'b1;
      assign ctl.left_gt  = 1'b0;
      assign left_ent     = new_ent;
    end else begin : g_body
      assign ctl.left_vld = vld[i-1];
      assign ctl.left_gt  = gt[i-1];
      assign left_ent     = ent[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    assign ctl.ins_en   = ins_en;
    assign ctl.drn_en   = shift;
    assign ctl.self_vld = vld[i];

    pds_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .gt        (gt[i])
    );
  end

  // Control: busy, fill count, overflow flag, drain and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      drain_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_acc && in_last_point) begin
        busy_r <= 1'b1;
      end
      if (pt_vld) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
        if (pt.last) begin
          drain_r <= 1'b1;
        end
      end
      if (shift) begin
        out_valid_r <= 1'b1;
        count_r     <= count_r - CNT_W'(1);
        if (final_shift) begin
          drain_r <= 1'b0;
          ovf_r   <= 1'b0;
          busy_r  <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (shift) begin
      out_point_index      <= ent[0].idx;
      out_x                <= ent[0].x;
      out_y                <= ent[0].y;
      out_distance_squared <= ent[0].key;
      out_last_out         <= final_shift;
      out_dropped_points   <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/pds_checker.sv @@
// ----------------------------------------------------------------------------
// Point sorter checker
// Port-level assertions on the point sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_sort_by_origin_distance_defines.svh"

module pds_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [pds_pkg::COORD_W-1:0] in_x_coord,
  input logic signed [pds_pkg::COORD_W-1:0] in_y_coord,
  input logic                               in_last_point,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pds_pkg::IDX_W-1:0]          out_point_index,
  input logic signed [pds_pkg::COORD_W-1:0] out_x,
  input logic signed [pds_pkg::COORD_W-1:0] out_y,
  input logic [pds_pkg::KEY_W-1:0]          out_distance_squared,
  input logic                               out_last_out,
  input logic                               out_dropped_points
);

  // A stalled result holds
  `PDS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_distance_squared) && $stable(out_point_index), "stalled result changed")

  // An accepted last request closes the input
  `PDS_ASSERT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_last_point |=> !in_ready, "input open after last request")

  // No new points while a set is still draining
  `PDS_ASSERT(a_drain_blocks, clk, rst_n, out_valid && !out_last_out |-> !in_ready, "input open during drain")

  // Drain runs without gaps
  `PDS_ASSERT(a_drain_dense, clk, rst_n, out_valid && out_ready && !out_last_out |=> out_valid, "gap in drain")

  // Reset empties the output
  `PDS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind point_sort_by_origin_distance pds_checker u_pds_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point sorter testbench
// Drives sets of signed points into the sorter and checks each emitted point
// against a sorted list kept beside the block: order by x*x+y*y, earlier
// arrival first on equal keys, overflow flag once the set exceeds capacity.
// Both sides idle at random; one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SET_DEPTH      = pds_pkg::MAX_POINTS_DEF;
  localparam int ITEM_TARGET    = 410;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;

  // One point as it should leave the block
  typedef struct {
    logic [pds_pkg::IDX_W-1:0]          index;
    logic signed [pds_pkg::COORD_W-1:0] x;
    logic signed [pds_pkg::COORD_W-1:0] y;
    logic [pds_pkg::KEY_W-1:0]          dist_sq;
    logic                               last;
    logic                               dropped;
  } sorted_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [pds_pkg::COORD_W-1:0] in_x_coord = '0;
  logic signed [pds_pkg::COORD_W-1:0] in_y_coord = '0;
  logic                               in_last_point = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [pds_pkg::IDX_W-1:0]          out_point_index;
  logic signed [pds_pkg::COORD_W-1:0] out_x;
  logic signed [pds_pkg::COORD_W-1:0] out_y;
  logic [pds_pkg::KEY_W-1:0]          out_distance_squared;
  logic                               out_last_out;
  logic                               out_dropped_points;

  // Sorted copy of the current set and the points due out
  pds_pkg::entry_t set_store[$];
  logic            set_overflow = 1'b0;
  sorted_result_t  points_due[$];
  sorted_result_t  next_due;

  int error_count  = 0;
  int result_count = 0;
  int points_sent  = 0;
  int burst_left   = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int pattern_age  = 0;
  int idle_cycles  = 0;
  logic [15:0] ready_pattern = 16'hffff;

  point_sort_by_origin_distance #(
    .MAX_POINTS (SET_DEPTH)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_x_coord           (in_x_coord),
    .in_y_coord           (in_y_coord),
    .in_last_point        (in_last_point),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_point_index      (out_point_index),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_distance_squared (out_distance_squared),
    .out_last_out         (out_last_out),
    .out_dropped_points   (out_dropped_points)
  );

  always #4 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Insert an accepted point into the sorted set; on last, queue the set
  function automatic void sort_point(input logic signed [pds_pkg::COORD_W-1:0] x,
                                     input logic signed [pds_pkg::COORD_W-1:0] y,
                                     input logic last);
    longint          xl;
    longint          yl;
    pds_pkg::entry_t e;
    sorted_result_t  r;
    int              pos;
    xl = x;
    yl = y;
    if (set_store.size() < SET_DEPTH) begin
      e.key = pds_pkg::KEY_W'(xl * xl + yl * yl);
      e.idx = pds_pkg::IDX_W'(set_store.size());
      e.x   = x;
      e.y   = y;
      // equal keys stay behind earlier arrivals
      pos = set_store.size();
      while (pos > 0 && set_store[pos-1].key > e.key) pos--;
      set_store.insert(pos, e);
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      foreach (set_store[i]) begin
        r.index   = set_store[i].idx;
        r.x       = set_store[i].x;
        r.y       = set_store[i].y;
        r.dist_sq = set_store[i].key;
        r.last    = (i == set_store.size() - 1);
        r.dropped = set_overflow;
        points_due.push_back(r);
      end
      set_store.delete();
      set_overflow = 1'b0;
    end
  endfunction

  // Offer one point; bursts of requests with random gaps between them
  task automatic send_point(input logic signed [pds_pkg::COORD_W-1:0] x,
                            input logic signed [pds_pkg::COORD_W-1:0] y,
                            input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_valid      <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    sort_point(x, y, last);
    burst_left--;
    points_sent++;
  endtask

  // Stop offering until every queued point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [pds_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      // small values give many equal keys
      1, 2, 3: return pds_pkg::COORD_W'($urandom_range(0, 10)) - 16'sd5;
      default: return pds_pkg::COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), i == n - 1);
  endtask

  // Set of one point at the largest key
  task automatic test_single_point();
    send_point(-16'sd32768, -16'sd32768, 1'b1);
  endtask

  // Coordinate extremes within one set
  task automatic test_extremes();
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(-16'sd1, 16'sd1, 1'b1);
  endtask

  // Equal keys come out in arrival order
  task automatic test_equal_keys();
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(-16'sd5, 16'sd0, 1'b0);
    send_point(16'sd4, -16'sd3, 1'b0);
    send_point(16'sd0, 16'sd5, 1'b1);
  endtask

  // Store full: the seventeenth point, marked last, is dropped
  task automatic test_store_full();
    for (int i = 0; i <= SET_DEPTH; i++)
      send_point(pds_pkg::COORD_W'(SET_DEPTH - i), pds_pkg::COORD_W'(i),
                 i == SET_DEPTH);
  endtask

  // Long output hold-off while the sender keeps offering the next set
  task automatic test_output_hold();
    burst_left   = 64;
    hold_request = LONG_HOLD;
    send_random_set(SET_DEPTH);
    send_random_set(10);
  endtask

  // Sender pauses until the previous set has fully drained
  task automatic test_drain_pause();
    send_random_set(5);
    wait_drained();
    send_random_set(3);
  endtask

  // Random sets, mostly within capacity, a few full or over
  task automatic test_random_sets();
    int n;
    while (points_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(SET_DEPTH, SET_DEPTH + 4);
        1:       n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      send_random_set(n);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  // Receiver: rotating ready pattern, reloaded now and then, plus long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      hold_left   = 0;
      pattern_age = 0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 2))
          0:       ready_pattern = 16'hffff;
          1:       ready_pattern = 16'($urandom);
          default: ready_pattern = 16'($urandom) | 16'($urandom);
        endcase
        pattern_age = $urandom_range(20, 80);
      end
      pattern_age--;
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ready_pattern[0];
      end
    end
  end

  task automatic compare_field(input string name,
                               input logic [pds_pkg::KEY_W-1:0] want,
                               input logic [pds_pkg::KEY_W-1:0] got);
    if (got !== want)
      flag_error($sformatf("result %0d %s: expected %h, got %h",
                           result_count, name, want, got));
  endtask

  // Check each emitted point against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (points_due.size() == 0) begin
        flag_error($sformatf("unexpected point idx %0d x %0d y %0d",
                             out_point_index, out_x, out_y));
      end else begin
        next_due = points_due.pop_front();
        compare_field("point_index", pds_pkg::KEY_W'(next_due.index),
                      pds_pkg::KEY_W'(out_point_index));
        compare_field("x", pds_pkg::KEY_W'(next_due.x), pds_pkg::KEY_W'(out_x));
        compare_field("y", pds_pkg::KEY_W'(next_due.y), pds_pkg::KEY_W'(out_y));
        compare_field("distance_squared", next_due.dist_sq, out_distance_squared);
        compare_field("last_out", pds_pkg::KEY_W'(next_due.last),
                      pds_pkg::KEY_W'(out_last_out));
        compare_field("dropped_points", pds_pkg::KEY_W'(next_due.dropped),
                      pds_pkg::KEY_W'(out_dropped_points));
      end
      result_count++;
    end
  end

  // Watchdog: cycles with no request taken on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_point();
    test_extremes();
    test_equal_keys();
    test_store_full();
    test_output_hold();
    test_drain_pause();
    test_random_sets();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pds_pkg.sv
rtl/pds_key.sv
rtl/pds_cell.sv
rtl/point_sort_by_origin_distance.sv
rtl/pds_checker.sv
dv/tb_top.sv
